@@ rtl/ddmc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ddmc_pkg;

    // datapath width of the shared multiply/divide unit
    localparam int DW = 64;
    // multiplier operand bits consumed, one per cycle
    localparam int MUL_STEPS = 24;

    localparam logic [1:0] MODE_PID   = 2'd0;
    localparam logic [1:0] MODE_CONST = 2'd1;
    localparam logic [1:0] MODE_TRAP  = 2'd2;

    localparam logic [2:0] REG_MODE  = 3'd0;
    localparam logic [2:0] REG_LGOAL = 3'd1;
    localparam logic [2:0] REG_RGOAL = 3'd2;
    localparam logic [2:0] REG_POWER = 3'd3;
    localparam logic [2:0] REG_RAMP  = 3'd4;

    localparam logic signed [DW-1:0] BRAKE_Q      = 64'sd655360;    // 10.0 in Q16
    localparam logic signed [DW-1:0] RAMP_START_Q = 64'sd2621440;   // 40.0 in Q16
    localparam logic signed [DW-1:0] RAMP_START   = 64'sd40;
    localparam logic signed [DW-1:0] RAMP_END     = 64'sd10;
    localparam logic signed [DW-1:0] BRAKE_ZONE   = 64'sd100;
    localparam logic signed [DW-1:0] ICAP_Q       = 64'sd1310720;   // 20.0 in Q16
    localparam logic signed [DW-1:0] PID_CAP      = 64'sd4294967296;
    localparam logic signed [DW-1:0] SUM_MAX      = 64'sd2147483647;
    localparam logic signed [DW-1:0] SUM_MIN      = -64'sd2147483648;

    localparam logic signed [DW-1:0] KP_STRAIGHT = 64'sd5243;
    localparam logic signed [DW-1:0] KP_TURN     = 64'sd34079;
    localparam logic signed [DW-1:0] KP_ARC      = 64'sd2621;
    localparam logic signed [DW-1:0] KI_SPIN     = 64'sd66;
    localparam logic signed [DW-1:0] KD_SPIN     = 64'sd163840;

    typedef struct packed {
        logic                 start;
        logic                 div;
        logic signed [DW-1:0] a;
        logic signed [DW-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic                 done;
        logic signed [DW-1:0] q;
    } alu_rsp_t;

    // sign of a target applied to a value
    function automatic logic signed [DW-1:0] dir_mul(input logic pos, input logic neg,
                                                     input logic signed [DW-1:0] x);
        logic signed [DW-1:0] r;
        r = '0;
        if (pos)
            r = x;
        else if (neg)
            r = -x;
        return r;
    endfunction

    // Q48.16 to integer power, truncated toward zero, saturated to +-127
    function automatic logic [7:0] to_drive(input logic signed [DW-1:0] q);
        logic signed [DW-1:0] t;
        logic [7:0]           r;
        t = q >>> 16;
        if (q[DW-1] && (q[15:0] != 16'd0))
            t = t + 64'sd1;
        if (t > 64'sd127)
            r = 8'sd127;
        else if (t < -64'sd127)
            r = -8'sd127;
        else
            r = t[7:0];
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/differential_drive_motion_controller_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// From input accept to m_tvalid: a start word, an unused mode or a constant or trapezoid brake passes
// through dispatch and finish only; constant, trapezoid and PID modes may also wait on the shared
// multiply/divide unit for each multiply and divide. A held output stalls the word in finish.
// One word in flight: the next word is taken the cycle after the result is registered.
// Reset (async, active low): drive_mode 2, goals 0, power_limit 110,
// ramp_distance 300, error sums and last errors 0, output empty.
module differential_drive_motion_controller_top #(
    parameter  int POSITION_BITS = 18,
    localparam int IN_W  = ((2 * POSITION_BITS + 7) / 8) * 8,
    localparam int CFG_W = (POSITION_BITS > 17) ? POSITION_BITS : 17
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,    // left_position, right_position
    input  logic             s_tuser,    // command
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [15:0]      m_tdata,    // left_drive, right_drive
    input  logic             cfg_we,
    input  logic [2:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int P  = POSITION_BITS;
    localparam int DW = ddmc_pkg::DW;
    localparam logic signed [DW-1:0] POS_MAX = (DW'(1) <<< (P - 1)) - DW'(1);
    localparam logic signed [DW-1:0] POS_MIN = -POS_MAX - DW'(1);

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH,
        S_C_MUL, S_C_DIV,
        S_T_MUL, S_T_DIV, S_T_SCALE, S_T_SMUL, S_T_SDIV, S_T_DIR,
        S_P_SIDE, S_P_KI, S_P_KP, S_P_KD, S_P_SCALE, S_P_SMUL, S_P_SDIV,
        S_FINISH
    } state_t;

    // configuration
    logic [1:0]          mode_reg;
    logic signed [P-1:0] lgoal_reg;
    logic signed [P-1:0] rgoal_reg;
    logic [6:0]          power_reg;
    logic [16:0]         ramp_reg;

    // loop state
    logic signed [31:0]  lsum_reg;
    logic signed [31:0]  rsum_reg;
    logic signed [P-1:0] llast_reg;
    logic signed [P-1:0] rlast_reg;

    // per-word working registers
    state_t               state_reg;
    logic                 issued_reg;
    logic                 cmd_reg;
    logic signed [P-1:0]  lp_reg;
    logic signed [P-1:0]  rp_reg;
    logic signed [DW-1:0] lq_reg;
    logic signed [DW-1:0] rq_reg;
    logic signed [DW-1:0] pq_reg;
    logic signed [DW-1:0] tmp_reg;
    logic signed [DW-1:0] acc_reg;
    logic                 side_reg;       // 0 left, 1 right
    logic                 long_left_reg;  // left side is the one held at full power
    logic                 accel_reg;
    logic                 m_tvalid_reg;
    logic [15:0]          m_tdata_reg;

    ddmc_pkg::alu_req_t req;
    ddmc_pkg::alu_rsp_t rsp;

    ddmc_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // ---------------------------------------------------------------
    // Operands derived from registers
    // ---------------------------------------------------------------
    logic signed [DW-1:0] lt_w, rt_w, alt_w, art_w, lp_w, rp_w;
    logic signed [DW-1:0] sp_w, st_w, mx_w, m_w, a2_w;
    logic                 l_pos, l_neg, r_pos, r_neg;
    logic [16:0]          ramp_eff;
    logic signed [DW-1:0] kp_w, ki_w, kd_w;

    assign lt_w  = DW'(lgoal_reg);
    assign rt_w  = DW'(rgoal_reg);
    assign lp_w  = DW'(lp_reg);
    assign rp_w  = DW'(rp_reg);
    assign l_neg = lgoal_reg[P-1];
    assign r_neg = rgoal_reg[P-1];
    assign l_pos = !l_neg && (lgoal_reg != '0);
    assign r_pos = !r_neg && (rgoal_reg != '0);
    assign alt_w = l_neg ? -lt_w : lt_w;
    assign art_w = r_neg ? -rt_w : rt_w;
    // summed distances (the trapezoid compares these doubled averages)
    assign sp_w  = (lp_reg[P-1] ? -lp_w : lp_w) + (rp_reg[P-1] ? -rp_w : rp_w);
    assign st_w  = alt_w + art_w;
    assign mx_w  = DW'(power_reg);
    assign m_w   = mx_w <<< 16;
    assign ramp_eff = (ramp_reg == 17'd0) ? 17'd1 : ramp_reg;
    assign a2_w  = DW'({ramp_eff, 1'b0});

    // gain set: straight, turn in place, or arc
    always_comb
    begin
        if (lgoal_reg == rgoal_reg)
        begin
            kp_w = ddmc_pkg::KP_STRAIGHT;
            ki_w = ddmc_pkg::KI_SPIN;
            kd_w = ddmc_pkg::KD_SPIN;
        end
        else if (alt_w == art_w)
        begin
            kp_w = ddmc_pkg::KP_TURN;
            ki_w = ddmc_pkg::KI_SPIN;
            kd_w = ddmc_pkg::KD_SPIN;
        end
        else
        begin
            kp_w = ddmc_pkg::KP_ARC;
            ki_w = '0;
            kd_w = '0;
        end
    end

    // PID side currently being worked
    logic signed [DW-1:0] goal_s, pos_s, last_s, sum_s, e_s, nsum_w;
    logic signed [31:0]   nsum32;
    logic                 pos_s_dir, neg_s_dir, pid_brake;
    logic signed [DW-1:0] ip_w, tot_w, tot_clamp, al_w, ar_w;

    assign goal_s    = side_reg ? rt_w : lt_w;
    assign pos_s     = side_reg ? rp_w : lp_w;
    assign last_s    = side_reg ? DW'(rlast_reg) : DW'(llast_reg);
    assign sum_s     = side_reg ? DW'(rsum_reg) : DW'(lsum_reg);
    assign pos_s_dir = side_reg ? r_pos : l_pos;
    assign neg_s_dir = side_reg ? r_neg : l_neg;
    assign e_s       = goal_s - pos_s;
    assign nsum_w    = sum_s + e_s;
    assign nsum32    = (nsum_w > ddmc_pkg::SUM_MAX) ? 32'sh7FFFFFFF :
                       (nsum_w < ddmc_pkg::SUM_MIN) ? 32'sh80000000 : nsum_w[31:0];
    // inside the brake zone, or no direction at all
    assign pid_brake = pos_s_dir ? (e_s <= ddmc_pkg::BRAKE_ZONE) :
                       neg_s_dir ? (e_s >= -ddmc_pkg::BRAKE_ZONE) : 1'b1;

    // integral term cap applies on the direction of travel only
    always_comb
    begin
        ip_w = rsp.q;
        if (pos_s_dir && (rsp.q > ddmc_pkg::ICAP_Q))
            ip_w = ddmc_pkg::ICAP_Q;
        else if (neg_s_dir && (rsp.q < -ddmc_pkg::ICAP_Q))
            ip_w = -ddmc_pkg::ICAP_Q;
    end

    assign tot_w     = acc_reg + rsp.q;
    assign tot_clamp = (tot_w > ddmc_pkg::PID_CAP) ? ddmc_pkg::PID_CAP :
                       (tot_w < -ddmc_pkg::PID_CAP) ? -ddmc_pkg::PID_CAP : tot_w;
    assign al_w      = lq_reg[DW-1] ? -lq_reg : lq_reg;
    assign ar_w      = rq_reg[DW-1] ? -rq_reg : rq_reg;

    // last errors, saturated to the position range
    logic signed [DW-1:0] lerr_w, rerr_w;
    logic signed [P-1:0]  lerr_sat, rerr_sat;

    assign lerr_w   = lt_w - lp_w;
    assign rerr_w   = rt_w - rp_w;
    assign lerr_sat = (lerr_w > POS_MAX) ? POS_MAX[P-1:0] :
                      (lerr_w < POS_MIN) ? POS_MIN[P-1:0] : lerr_w[P-1:0];
    assign rerr_sat = (rerr_w > POS_MAX) ? POS_MAX[P-1:0] :
                      (rerr_w < POS_MIN) ? POS_MIN[P-1:0] : rerr_w[P-1:0];

    // ---------------------------------------------------------------
    // Requests to the shared unit, one per arithmetic state
    // ---------------------------------------------------------------
    always_comb
    begin
        req       = '0;
        req.start = !issued_reg;
        case (state_reg)
            S_C_MUL:
            begin
                req.a = long_left_reg ? art_w : alt_w;
                req.b = mx_w;
            end
            S_C_DIV, S_T_SDIV:
            begin
                req.div = 1'b1;
                req.a   = tmp_reg;
                req.b   = long_left_reg ? alt_w : art_w;
            end
            S_T_MUL:
            begin
                req.a = accel_reg ? sp_w : a2_w - (st_w - sp_w);
                req.b = accel_reg ? mx_w - ddmc_pkg::RAMP_START : mx_w - ddmc_pkg::RAMP_END;
            end
            S_T_DIV:
            begin
                req.div = 1'b1;
                req.a   = tmp_reg;
                req.b   = a2_w;
            end
            S_T_SMUL:
            begin
                req.a = long_left_reg ? art_w : alt_w;
                req.b = pq_reg;
            end
            S_P_KI:
            begin
                req.a = sum_s;
                req.b = ki_w;
            end
            S_P_KP:
            begin
                req.a = e_s;
                req.b = kp_w;
            end
            S_P_KD:
            begin
                req.a = e_s - last_s;
                req.b = kd_w;
            end
            S_P_SMUL:
            begin
                req.a = long_left_reg ? ar_w : al_w;
                req.b = m_w;
            end
            S_P_SDIV:
            begin
                req.div = 1'b1;
                req.a   = tmp_reg;
                req.b   = long_left_reg ? al_w : ar_w;
            end
            default:
            begin
                req.start = 1'b0;
            end
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= ddmc_pkg::MODE_TRAP;
            lgoal_reg <= '0;
            rgoal_reg <= '0;
            power_reg <= 7'd110;
            ramp_reg  <= 17'd300;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ddmc_pkg::REG_MODE:  mode_reg  <= cfg_data[1:0];
                ddmc_pkg::REG_LGOAL: lgoal_reg <= cfg_data[P-1:0];
                ddmc_pkg::REG_RGOAL: rgoal_reg <= cfg_data[P-1:0];
                ddmc_pkg::REG_POWER: power_reg <= cfg_data[6:0];
                ddmc_pkg::REG_RAMP:  ramp_reg  <= cfg_data[16:0];
                default:             ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            issued_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
            lsum_reg     <= '0;
            rsum_reg     <= '0;
            llast_reg    <= '0;
            rlast_reg    <= '0;
        end
        else
        begin
            if (req.start)
                issued_reg <= 1'b1;
            if (rsp.done)
                issued_reg <= 1'b0;
            // FINISH reloads the output register itself
            if (m_tvalid_reg && m_tready && (state_reg != S_FINISH))
                m_tvalid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        cmd_reg   <= s_tuser;
                        lp_reg    <= s_tdata[P-1:0];
                        rp_reg    <= s_tdata[2*P-1:P];
                        state_reg <= S_DISPATCH;
                    end
                end

                S_DISPATCH:
                begin
                    side_reg <= 1'b0;
                    if (cmd_reg)
                    begin
                        lq_reg    <= '0;
                        rq_reg    <= '0;
                        lsum_reg  <= '0;
                        rsum_reg  <= '0;
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        case (mode_reg)
                            ddmc_pkg::MODE_CONST:
                            begin
                                if (sp_w < st_w)
                                begin
                                    long_left_reg <= (alt_w > art_w);
                                    if (alt_w > art_w)
                                        lq_reg <= ddmc_pkg::dir_mul(l_pos, l_neg, m_w);
                                    else
                                        rq_reg <= ddmc_pkg::dir_mul(r_pos, r_neg, m_w);
                                    state_reg <= S_C_MUL;
                                end
                                else
                                begin
                                    lq_reg <= ddmc_pkg::dir_mul(l_pos, l_neg, -ddmc_pkg::BRAKE_Q);
                                    rq_reg <= ddmc_pkg::dir_mul(r_pos, r_neg, -ddmc_pkg::BRAKE_Q);
                                    state_reg <= S_FINISH;
                                end
                            end
                            ddmc_pkg::MODE_TRAP:
                            begin
                                if (sp_w < st_w)
                                begin
                                    if ((sp_w < a2_w) && ((sp_w <<< 1) < st_w))
                                    begin
                                        accel_reg <= 1'b1;
                                        state_reg <= S_T_MUL;
                                    end
                                    else if (sp_w < st_w - a2_w)
                                    begin
                                        pq_reg    <= m_w;
                                        state_reg <= S_T_SCALE;
                                    end
                                    else
                                    begin
                                        accel_reg <= 1'b0;
                                        state_reg <= S_T_MUL;
                                    end
                                end
                                else
                                begin
                                    lq_reg <= ddmc_pkg::dir_mul(l_pos, l_neg, -ddmc_pkg::BRAKE_Q);
                                    rq_reg <= ddmc_pkg::dir_mul(r_pos, r_neg, -ddmc_pkg::BRAKE_Q);
                                    state_reg <= S_FINISH;
                                end
                            end
                            ddmc_pkg::MODE_PID:
                            begin
                                state_reg <= S_P_SIDE;
                            end
                            default:
                            begin
                                // unused mode code: zero power, last errors still tracked
                                lq_reg    <= '0;
                                rq_reg    <= '0;
                                state_reg <= S_FINISH;
                            end
                        endcase
                    end
                end

                // constant mode: short side = max * short / long
                S_C_MUL:
                begin
                    if (rsp.done)
                    begin
                        tmp_reg   <= rsp.q;
                        state_reg <= S_C_DIV;
                    end
                end
                S_C_DIV:
                begin
                    if (rsp.done)
                    begin
                        if (long_left_reg)
                            rq_reg <= ddmc_pkg::dir_mul(r_pos, r_neg, rsp.q <<< 16);
                        else
                            lq_reg <= ddmc_pkg::dir_mul(l_pos, l_neg, rsp.q <<< 16);
                        state_reg <= S_FINISH;
                    end
                end

                // trapezoid: ramp product, then divide by doubled ramp length
                S_T_MUL:
                begin
                    if (rsp.done)
                    begin
                        tmp_reg   <= rsp.q <<< 16;
                        state_reg <= S_T_DIV;
                    end
                end
                S_T_DIV:
                begin
                    if (rsp.done)
                    begin
                        pq_reg    <= accel_reg ? ddmc_pkg::RAMP_START_Q + rsp.q : m_w - rsp.q;
                        state_reg <= S_T_SCALE;
                    end
                end
                S_T_SCALE:
                begin
                    lq_reg        <= pq_reg;
                    rq_reg        <= pq_reg;
                    long_left_reg <= (alt_w > art_w);
                    state_reg     <= (alt_w != art_w) ? S_T_SMUL : S_T_DIR;
                end
                S_T_SMUL:
                begin
                    if (rsp.done)
                    begin
                        tmp_reg   <= rsp.q;
                        state_reg <= S_T_SDIV;
                    end
                end
                S_T_SDIV:
                begin
                    if (rsp.done)
                    begin
                        if (long_left_reg)
                            rq_reg <= rsp.q;
                        else
                            lq_reg <= rsp.q;
                        state_reg <= S_T_DIR;
                    end
                end
                S_T_DIR:
                begin
                    lq_reg    <= ddmc_pkg::dir_mul(l_pos, l_neg, lq_reg);
                    rq_reg    <= ddmc_pkg::dir_mul(r_pos, r_neg, rq_reg);
                    state_reg <= S_FINISH;
                end

                // PID, left side then right side
                S_P_SIDE:
                begin
                    if (pid_brake)
                    begin
                        if (side_reg)
                        begin
                            rq_reg    <= ddmc_pkg::dir_mul(r_pos, r_neg, -ddmc_pkg::BRAKE_Q);
                            state_reg <= S_P_SCALE;
                        end
                        else
                        begin
                            lq_reg   <= ddmc_pkg::dir_mul(l_pos, l_neg, -ddmc_pkg::BRAKE_Q);
                            side_reg <= 1'b1;
                        end
                    end
                    else
                    begin
                        if (side_reg)
                            rsum_reg <= nsum32;
                        else
                            lsum_reg <= nsum32;
                        state_reg <= S_P_KI;
                    end
                end
                S_P_KI:
                begin
                    if (rsp.done)
                    begin
                        acc_reg   <= ip_w;
                        state_reg <= S_P_KP;
                    end
                end
                S_P_KP:
                begin
                    if (rsp.done)
                    begin
                        acc_reg   <= tot_w;
                        state_reg <= S_P_KD;
                    end
                end
                S_P_KD:
                begin
                    if (rsp.done)
                    begin
                        if (side_reg)
                        begin
                            rq_reg    <= tot_clamp;
                            state_reg <= S_P_SCALE;
                        end
                        else
                        begin
                            lq_reg    <= tot_clamp;
                            side_reg  <= 1'b1;
                            state_reg <= S_P_SIDE;
                        end
                    end
                end
                S_P_SCALE:
                begin
                    if ((al_w > ar_w) && (al_w > m_w))
                    begin
                        long_left_reg <= 1'b1;
                        state_reg     <= S_P_SMUL;
                    end
                    else if (ar_w > m_w)
                    begin
                        long_left_reg <= 1'b0;
                        state_reg     <= S_P_SMUL;
                    end
                    else
                    begin
                        state_reg <= S_FINISH;
                    end
                end
                S_P_SMUL:
                begin
                    if (rsp.done)
                    begin
                        tmp_reg   <= rsp.q;
                        state_reg <= S_P_SDIV;
                    end
                end
                S_P_SDIV:
                begin
                    if (rsp.done)
                    begin
                        if (long_left_reg)
                        begin
                            rq_reg <= ddmc_pkg::dir_mul(r_pos, r_neg, rsp.q);
                            lq_reg <= ddmc_pkg::dir_mul(l_pos, l_neg, m_w);
                        end
                        else
                        begin
                            lq_reg <= ddmc_pkg::dir_mul(l_pos, l_neg, rsp.q);
                            rq_reg <= ddmc_pkg::dir_mul(r_pos, r_neg, m_w);
                        end
                        state_reg <= S_FINISH;
                    end
                end

                // update last errors and hand the word to the output register
                S_FINISH:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tdata_reg  <= {ddmc_pkg::to_drive(rq_reg), ddmc_pkg::to_drive(lq_reg)};
                        m_tvalid_reg <= 1'b1;
                        llast_reg    <= cmd_reg ? lgoal_reg : lerr_sat;
                        rlast_reg    <= cmd_reg ? rgoal_reg : rerr_sat;
                        state_reg    <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/ddmc_muldiv.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Shared sign-magnitude multiply (one operand bit per cycle) and
// restoring divide (one quotient bit per cycle, truncates toward zero).
module ddmc_muldiv (
    input  logic               clk,
    input  logic               rst_n,
    input  ddmc_pkg::alu_req_t req,
    output ddmc_pkg::alu_rsp_t rsp
);

    localparam int DW = ddmc_pkg::DW;
    localparam int MS = ddmc_pkg::MUL_STEPS;
    localparam int CW = $clog2(DW);

    typedef enum logic [1:0] {U_IDLE, U_MUL, U_DIV, U_DONE} ustate_t;

    ustate_t              state_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 neg_reg;
    logic                 div_reg;
    logic [DW:0]          rem_reg;
    logic [DW-1:0]        quo_reg;
    logic [DW-1:0]        opd_reg;
    logic [MS-1:0]        mlt_reg;
    logic                 done_reg;
    logic signed [DW-1:0] q_reg;

    logic [DW-1:0] a_mag;
    logic [DW-1:0] b_mag;
    logic [DW-1:0] mag;
    logic [DW:0]   shx;
    logic [DW+1:0] add_x;
    logic [DW+1:0] add_y;
    logic [DW+1:0] add_s;
    logic          is_div;

    assign a_mag  = req.a[DW-1] ? -req.a : req.a;
    assign b_mag  = req.b[DW-1] ? -req.b : req.b;
    assign mag    = div_reg ? quo_reg : rem_reg[DW-1:0];
    assign shx    = {rem_reg[DW-1:0], quo_reg[DW-1]};
    assign is_div = (state_reg == U_DIV);

    // the one adder: accumulate for multiply, trial subtract for divide
    assign add_x = is_div ? {1'b0, shx} : {2'b00, rem_reg[DW-1:0]};
    assign add_y = is_div ? ~{2'b00, opd_reg} : {2'b00, opd_reg};
    assign add_s = add_x + add_y + {{(DW+1){1'b0}}, is_div};

    assign rsp.done = done_reg;
    assign rsp.q    = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                U_IDLE:
                begin
                    if (req.start)
                    begin
                        neg_reg <= req.a[DW-1] ^ req.b[DW-1];
                        div_reg <= req.div;
                        rem_reg <= '0;
                        cnt_reg <= '0;
                        if (req.div)
                        begin
                            quo_reg   <= a_mag;
                            opd_reg   <= b_mag;
                            state_reg <= U_DIV;
                        end
                        else
                        begin
                            opd_reg   <= a_mag;
                            mlt_reg   <= b_mag[MS-1:0];
                            state_reg <= U_MUL;
                        end
                    end
                end
                U_MUL:
                begin
                    if (mlt_reg[0])
                        rem_reg <= {1'b0, add_s[DW-1:0]};
                    opd_reg <= opd_reg << 1;
                    mlt_reg <= mlt_reg >> 1;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CW'(MS - 1))
                        state_reg <= U_DONE;
                end
                U_DIV:
                begin
                    quo_reg <= {quo_reg[DW-2:0], ~add_s[DW+1]};
                    rem_reg <= add_s[DW+1] ? shx : add_s[DW:0];
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CW'(DW - 1))
                        state_reg <= U_DONE;
                end
                U_DONE:
                begin
                    q_reg     <= neg_reg ? -$signed(mag) : $signed(mag);
                    done_reg  <= 1'b1;
                    state_reg <= U_IDLE;
                end
                default:
                begin
                    state_reg <= U_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
